// ----- rtl/cpts_pkg.sv -----
// cpts_pkg.sv: shared types, codes and constants of the counter priority task scheduler
// holds the command codes, sequencer states, task row layout and counter unit types
// no dependencies
package cpts_pkg;

	localparam int CMD_W   = 3;
	localparam int SLOT_FW = 6;
	localparam int PRIO_W  = 8;
	localparam int DEPTH_W = 8;
	localparam int CNT_W   = 16;

	localparam int IN_W  = 24;
	localparam int OUT_W = 16;

	localparam int TASK_SLOTS_DEF = 64;
	localparam int MAX_ROUNDS_DEF = 16;

	localparam logic signed [CNT_W-1:0] CNT_MAX = 16'sh7fff;
	localparam logic signed [CNT_W-1:0] CNT_MIN = -16'sh8000;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK    = 3'd0,
		CMD_YIELD   = 3'd1,
		CMD_EXIT    = 3'd2,
		CMD_PDIS    = 3'd3,
		CMD_PEN     = 3'd4,
		CMD_CREATE  = 3'd5
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD,
		ST_SCAN,
		ST_SCAN_END,
		ST_RECOMP,
		ST_DONE
	} state_t;

	typedef enum logic {
		ALU_DEC,
		ALU_RECOMP
	} alu_op_t;

	typedef struct packed {
		logic signed [CNT_W-1:0] cnt;
		logic [PRIO_W-1:0]       prio;
		logic [DEPTH_W-1:0]      depth;
	} row_t;

	localparam int ROW_W = $bits(row_t);

	typedef struct packed {
		alu_op_t                 op;
		logic signed [CNT_W-1:0] cnt;
		logic [PRIO_W-1:0]       prio;
		logic signed [CNT_W-1:0] best;
	} alu_in_t;

	typedef struct packed {
		logic signed [CNT_W-1:0] res;
		logic                    le_zero;
		logic                    gt;
	} alu_out_t;

	// row contents before the first write: slot 0 starts with priority one
	function automatic row_t row_default(input logic is_slot0);
		row_t r;
		r.cnt   = '0;
		r.prio  = is_slot0 ? PRIO_W'(1) : '0;
		r.depth = '0;
		return r;
	endfunction

endpackage

// ----- rtl/cpts_ram.sv -----
// cpts_ram.sv: generic single write port, single read port ram with registered read
// used for the task table; no package dependency
module cpts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/cpts_alu.sv -----
// cpts_alu.sv: shared counter unit of the scheduler
// saturating decrement, halve-and-add recompute and the signed compare for the pick
// depends on cpts_pkg
module cpts_alu (
	input  cpts_pkg::alu_in_t  a_in,
	output cpts_pkg::alu_out_t a_out
);
	import cpts_pkg::*;

	logic signed [CNT_W:0] dec_w;
	logic signed [CNT_W:0] rec_w;
	logic signed [CNT_W-1:0] res;

	always_comb begin
		dec_w = {a_in.cnt[CNT_W-1], a_in.cnt} - (CNT_W+1)'(1);
		// floor halve, then add the unsigned priority
		rec_w = {a_in.cnt[CNT_W-1], a_in.cnt[CNT_W-1], a_in.cnt[CNT_W-1:1]}
			+ $signed({{(CNT_W+1-PRIO_W){1'b0}}, a_in.prio});
		case (a_in.op)
			ALU_DEC: begin
				if (dec_w < $signed({CNT_MIN[CNT_W-1], CNT_MIN})) begin
					res = CNT_MIN;
				end else begin
					res = dec_w[CNT_W-1:0];
				end
			end
			ALU_RECOMP: begin
				if (rec_w > $signed({CNT_MAX[CNT_W-1], CNT_MAX})) begin
					res = CNT_MAX;
				end else begin
					res = rec_w[CNT_W-1:0];
				end
			end
			default: begin
				res = a_in.cnt;
			end
		endcase
		a_out.res     = res;
		a_out.le_zero = (res <= $signed(CNT_W'(0)));
		a_out.gt      = (a_in.cnt > a_in.best);
	end

endmodule

// ----- rtl/counter_priority_task_scheduler.sv -----
// counter_priority_task_scheduler.sv: top level of the counter based priority task scheduler
// sequencer, task table ram, valid/zombie bits and the shared counter unit
// depends on cpts_pkg, cpts_ram, cpts_alu
//
// channel  dir  handshake          payload
// s_axis   in   s_tvalid/s_tready  s_tdata: command[2:0] slot[8:3] priority_req[16:9]
// m_axis   out  m_tvalid/m_tready  m_tdata: switched[0] current_slot[6:1]
//                                           previous_slot[12:7] none_runnable[13]
//                                           round_limit_hit[14]
//
// a request without a reschedule passes through accept, table update and result
// a reschedule adds a table scan, and while the best count is zero and rounds remain,
// recompute passes each with a rescan, all through the single ram port pair and counter unit
// one request at a time; s_tready is high only while idle, a finished result waits
// in the output register while the next request is taken
// reset is asynchronous, active low; the table rows read as their reset values until written
module counter_priority_task_scheduler #(
	parameter int TASK_SLOTS = cpts_pkg::TASK_SLOTS_DEF,
	parameter int MAX_ROUNDS = cpts_pkg::MAX_ROUNDS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [cpts_pkg::IN_W-1:0]  s_tdata,  // command, slot, priority_req
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [cpts_pkg::OUT_W-1:0] m_tdata   // switched, current_slot, previous_slot,
	                                             // none_runnable, round_limit_hit
);
	import cpts_pkg::*;

	localparam int SW = $clog2(TASK_SLOTS);
	localparam int RW = $clog2(MAX_ROUNDS + 1);
	localparam logic [SW-1:0] LAST = SW'(TASK_SLOTS - 1);

	state_t state_q, state_d;

	logic [CMD_W-1:0]   cmd_q;
	logic [SLOT_FW-1:0] slot_q;
	logic [PRIO_W-1:0]  prio_q;
	logic [SW-1:0]      run_q, prev_q;

	logic [TASK_SLOTS-1:0] vld_q, zmb_q, wr_q;

	logic [SW-1:0] idx_q, rd_idx_s1, raddr, waddr;
	logic          iss_done_q, rd_v_s1, issue;

	logic                    found_q;
	logic signed [CNT_W-1:0] best_cnt_q;
	logic [SW-1:0]           best_idx_q;
	logic [RW-1:0]           rounds_q;
	logic                    none_q, limit_q;

	logic              m_tvalid_q;
	logic [OUT_W-2:0]  out_q;

	logic [ROW_W-1:0] ram_rdata;
	row_t             row_rd, wrow;
	logic             we, resched, cand, create_ok, scan_last, recomp_go, out_free;

	alu_in_t  a_in;
	alu_out_t a_out;

	cpts_ram #(
		.WIDTH (ROW_W),
		.DEPTH (TASK_SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wrow),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	cpts_alu u_alu (
		.a_in  (a_in),
		.a_out (a_out)
	);

	assign raddr     = (state_q == ST_SCAN || state_q == ST_RECOMP) ? idx_q : run_q;
	assign issue     = (state_q == ST_SCAN || state_q == ST_RECOMP) && !iss_done_q;
	assign row_rd    = wr_q[rd_idx_s1] ? row_t'(ram_rdata) : row_default(rd_idx_s1 == '0);
	assign create_ok = (32'(slot_q) < 32'(TASK_SLOTS));
	assign scan_last = rd_v_s1 && (rd_idx_s1 == LAST);
	assign recomp_go = found_q && (best_cnt_q == '0) && (rounds_q < RW'(MAX_ROUNDS));
	assign out_free  = !m_tvalid_q || m_tready;

	always_comb begin
		a_in.op   = (state_q == ST_RECOMP) ? ALU_RECOMP : ALU_DEC;
		a_in.cnt  = row_rd.cnt;
		a_in.prio = row_rd.prio;
		a_in.best = best_cnt_q;
	end

	// table update, write port and candidate select
	always_comb begin
		we      = 1'b0;
		waddr   = run_q;
		wrow    = row_rd;
		resched = 1'b0;
		cand    = 1'b0;
		case (state_q)
			ST_MOD: begin
				case (cmd_q)
					CMD_TICK: begin
						we = 1'b1;
						if (a_out.le_zero && row_rd.depth == '0) begin
							wrow.cnt = '0;
							resched  = 1'b1;
						end else begin
							wrow.cnt = a_out.res;
						end
					end
					CMD_YIELD, CMD_EXIT: begin
						we       = 1'b1;
						wrow.cnt = '0;
						resched  = 1'b1;
					end
					CMD_PDIS: begin
						we = 1'b1;
						if (row_rd.depth != '1) begin
							wrow.depth = row_rd.depth + DEPTH_W'(1);
						end
					end
					CMD_PEN: begin
						we = 1'b1;
						if (row_rd.depth != '0) begin
							wrow.depth = row_rd.depth - DEPTH_W'(1);
						end
					end
					CMD_CREATE: begin
						we         = create_ok;
						waddr      = SW'(slot_q);
						wrow.cnt   = CNT_W'(prio_q);
						wrow.prio  = prio_q;
						wrow.depth = '0;
					end
					default: begin
					end
				endcase
			end
			ST_SCAN: begin
				cand = rd_v_s1 && vld_q[rd_idx_s1] && !zmb_q[rd_idx_s1]
					&& !row_rd.cnt[CNT_W-1] && (!found_q || a_out.gt);
			end
			ST_RECOMP: begin
				if (rd_v_s1 && vld_q[rd_idx_s1]) begin
					we       = 1'b1;
					waddr    = rd_idx_s1;
					wrow.cnt = a_out.res;
				end
			end
			default: begin
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_MOD;
				end
			end
			ST_MOD: begin
				state_d = resched ? ST_SCAN : ST_DONE;
			end
			ST_SCAN: begin
				if (scan_last) begin
					state_d = ST_SCAN_END;
				end
			end
			ST_SCAN_END: begin
				state_d = recomp_go ? ST_RECOMP : ST_DONE;
			end
			ST_RECOMP: begin
				if (scan_last) begin
					state_d = ST_SCAN;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// port outputs
	always_comb begin
		s_tready = (state_q == ST_IDLE);
		m_tvalid = m_tvalid_q;
		m_tdata  = {1'b0, out_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			run_q      <= '0;
			prev_q     <= '0;
			vld_q      <= TASK_SLOTS'(1);
			zmb_q      <= '0;
			wr_q       <= '0;
			idx_q      <= '0;
			iss_done_q <= 1'b0;
			rd_v_s1    <= 1'b0;
			found_q    <= 1'b0;
			rounds_q   <= '0;
			none_q     <= 1'b0;
			limit_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= issue;

			if (state_q == ST_IDLE && s_tvalid) begin
				prev_q  <= run_q;
				none_q  <= 1'b0;
				limit_q <= 1'b0;
			end

			if (we) begin
				wr_q[waddr] <= 1'b1;
			end
			if (state_q == ST_MOD && cmd_q == CMD_CREATE && create_ok) begin
				vld_q[SW'(slot_q)] <= 1'b1;
				zmb_q[SW'(slot_q)] <= 1'b0;
			end
			if (state_q == ST_MOD && cmd_q == CMD_EXIT) begin
				zmb_q[run_q] <= 1'b1;
			end

			if (issue) begin
				if (idx_q == LAST) begin
					iss_done_q <= 1'b1;
				end else begin
					idx_q <= idx_q + SW'(1);
				end
			end

			if (cand) begin
				found_q <= 1'b1;
			end

			if (state_q == ST_SCAN_END && !recomp_go) begin
				if (!found_q) begin
					run_q  <= '0;
					none_q <= 1'b1;
				end else begin
					run_q <= best_idx_q;
					if (best_cnt_q == '0) begin
						limit_q <= 1'b1;
					end
				end
			end

			// each table pass starts from slot 0
			if (state_d == ST_SCAN && state_q != ST_SCAN) begin
				idx_q      <= '0;
				iss_done_q <= 1'b0;
				found_q    <= 1'b0;
				if (state_q == ST_MOD) begin
					rounds_q <= '0;
				end
			end
			if (state_d == ST_RECOMP && state_q != ST_RECOMP) begin
				idx_q      <= '0;
				iss_done_q <= 1'b0;
				rounds_q   <= rounds_q + RW'(1);
			end

			// a new result may replace the one taken in the same cycle
			if (state_q == ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= raddr;
		if (state_q == ST_IDLE && s_tvalid) begin
			cmd_q  <= s_tdata[CMD_W-1:0];
			slot_q <= s_tdata[CMD_W +: SLOT_FW];
			prio_q <= s_tdata[CMD_W+SLOT_FW +: PRIO_W];
		end
		if (cand) begin
			best_cnt_q <= row_rd.cnt;
			best_idx_q <= rd_idx_s1;
		end
		if (state_q == ST_DONE && out_free) begin
			out_q <= {limit_q, none_q, SLOT_FW'(prev_q), SLOT_FW'(run_q), run_q != prev_q};
		end
	end

`ifndef SYNTH
	a_run_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(run_q) < 32'(TASK_SLOTS))
		else $error("running slot beyond the task table");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside the done state");

	a_none_is_slot0: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && out_q[13]) |-> (out_q[6:1] == '0 && !out_q[14]))
		else $error("no runnable task but slot 0 not chosen, or round limit also set");

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || state_q == ST_RECOMP) |-> !s_tready)
		else $error("request taken during a table pass");
`endif

endmodule
